// ===== rtl/x86enc_pkg.sv =====
// Shared types and constants for the x86 subset instruction encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package x86enc_pkg;

  // Width of the running output offset; addresses wrap at this width
  localparam int OFFSET_BITS = 16;
  // Signed width that holds target - (offset + length) exactly
  localparam int REL_BITS = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

  // Depth of the request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Longest instruction in bytes
  localparam int MAX_BYTES = 6;

  // Instruction kinds as they arrive
  typedef enum logic [4:0] {
    OP_MOV_RR  = 5'd0,
    OP_MOV_LD  = 5'd1,
    OP_MOV_ST  = 5'd2,
    OP_MOV_IMM = 5'd3,
    OP_ADD_RR  = 5'd4,
    OP_SUB_RR  = 5'd5,
    OP_CMP_RR  = 5'd6,
    OP_ADD_IMM = 5'd7,
    OP_SUB_IMM = 5'd8,
    OP_CMP_IMM = 5'd9,
    OP_INT     = 5'd10,
    OP_INC     = 5'd11,
    OP_DEC     = 5'd12,
    OP_JMP     = 5'd13,
    OP_JE      = 5'd14,
    OP_JNE     = 5'd15,
    OP_LOOP    = 5'd16,
    OP_PUSH    = 5'd17,
    OP_POP     = 5'd18,
    OP_RET     = 5'd19,
    OP_CALL    = 5'd20,
    OP_NOP     = 5'd21,
    OP_DATA    = 5'd22
  } op_t;

  // Opcode bytes
  localparam logic [7:0] OPC_MOV_STORE = 8'h89;
  localparam logic [7:0] OPC_MOV_LOAD  = 8'h8B;
  localparam logic [7:0] OPC_MOV_IMM   = 8'hB8;
  localparam logic [7:0] OPC_ADD_RR    = 8'h01;
  localparam logic [7:0] OPC_SUB_RR    = 8'h29;
  localparam logic [7:0] OPC_CMP_RR    = 8'h39;
  localparam logic [7:0] OPC_GRP1_IMM  = 8'h81;
  localparam logic [7:0] MODRM_ADD_IMM = 8'hC0;
  localparam logic [7:0] MODRM_SUB_IMM = 8'hE8;
  localparam logic [7:0] MODRM_CMP_IMM = 8'hF8;
  localparam logic [7:0] OPC_INT       = 8'hCD;
  localparam logic [7:0] OPC_INC       = 8'h40;
  localparam logic [7:0] OPC_DEC       = 8'h48;
  localparam logic [7:0] OPC_JMP       = 8'hE9;
  localparam logic [7:0] OPC_TWO_BYTE  = 8'h0F;
  localparam logic [7:0] OPC_JE_2ND    = 8'h84;
  localparam logic [7:0] OPC_JNE_2ND   = 8'h85;
  localparam logic [7:0] OPC_LOOP      = 8'hE2;
  localparam logic [7:0] OPC_PUSH      = 8'h50;
  localparam logic [7:0] OPC_POP       = 8'h58;
  localparam logic [7:0] OPC_RET       = 8'hC3;
  localparam logic [7:0] OPC_CALL      = 8'hE8;
  localparam logic [7:0] OPC_NOP       = 8'h90;

  // One encoded instruction waiting for emission
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] code;   // byte 0 is emitted first
    logic [2:0]                len;    // bytes to emit, 1 to 6
    logic [OFFSET_BITS-1:0]    start;  // offset of the first byte
    logic                      err;    // loop target out of range
  } enc_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/x86_subset_instruction_encoder.sv =====
// Top level of the x86 subset instruction encoder: front, queue and back.
// Depends on x86enc_pkg, x86enc_front, x86enc_queue and x86enc_back.
//
// Each instruction request yields its machine-code bytes (1 to 6) through
// the back end's single byte lane, one result per cycle while m_tready
// holds, each tagged with its output offset; tlast marks the final byte.
// A new request is taken whenever the two-entry queue has room, so one-byte
// instructions stream at one per cycle while m_tready holds. A LOOP whose
// target is out of signed 8-bit range gives one result with tuser set, a
// zero byte and no offset advance. Unknown operation codes are taken and
// dropped. The user must write load_base through the cfg port only while
// the block is idle; the block does not enforce it.
module x86_subset_instruction_encoder import x86enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,    // load_base
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,     // first_reg[2:0], second_reg[5:3],
                                   // immediate[37:6], target_address[53:38]
  input  logic [5:0]  s_tuser,     // operation[4:0], imm_is_symbol[5]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // code_byte[7:0], byte_address[23:8]
  output logic        m_tlast,     // last_of_run
  output logic [0:0]  m_tuser      // range_error[0]
);

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  enc_entry_t push_entry;
  enc_entry_t head;

  x86enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  x86enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  x86enc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // A range error is a lone zero byte
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("range error result not a lone zero byte");

  // Bytes of one instruction follow without a gap
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside an instruction's byte run");

  // No result appears from an empty queue
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !q_stat.valid && !m_tvalid |=> !m_tvalid)
    else $error("result produced with nothing queued");

  // A queued request reaches the output stage when it is free
  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_stat.valid && !m_tvalid |=> m_tvalid)
    else $error("queued request not moved to the output");

endmodule

// ===== rtl/x86enc_front.sv =====
// Front end: takes instruction requests, encodes them into byte groups and
// tracks the output offset. Depends on x86enc_pkg.
module x86enc_front import x86enc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic [5:0]   s_tuser,
  input  q_stat_t      q_stat,
  output logic         push,
  output enc_entry_t   push_entry
);

  logic [15:0]            load_base;
  logic [OFFSET_BITS-1:0] offset;

  op_t                    op;
  logic [2:0]             f;
  logic [2:0]             s;
  logic [31:0]            imm;
  logic [15:0]            target;
  logic [31:0]            imm_eff;
  logic [2:0]             len;
  logic                   known;
  logic signed [REL_BITS-1:0] rel;
  logic [31:0]            rel32;
  logic                   loop_err;
  logic                   accept;
  logic [2:0]             advance;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_stat.full;
  assign accept    = s_tvalid && s_tready;

  // Unpack the request
  assign op     = op_t'(s_tuser[4:0]);
  assign f      = s_tdata[2:0];
  assign s      = s_tdata[5:3];
  assign imm    = s_tdata[37:6];
  assign target = s_tdata[53:38];

  // Relocate symbol-derived immediates
  assign imm_eff = s_tuser[5] ? (imm + {16'd0, load_base}) : imm;

  // Instruction length
  always_comb begin
    known = 1'b1;
    unique case (op)
      OP_INC, OP_DEC, OP_PUSH, OP_POP, OP_RET, OP_NOP, OP_DATA: len = 3'd1;
      OP_MOV_RR, OP_MOV_LD, OP_MOV_ST, OP_ADD_RR, OP_SUB_RR, OP_CMP_RR,
      OP_INT, OP_LOOP: len = 3'd2;
      OP_MOV_IMM, OP_JMP, OP_CALL: len = 3'd5;
      OP_ADD_IMM, OP_SUB_IMM, OP_CMP_IMM, OP_JE, OP_JNE: len = 3'd6;
      default: begin
        len   = 3'd0;
        known = 1'b0;
      end
    endcase
  end

  // Branch displacement from the offset just past the instruction
  assign rel = $signed(REL_BITS'(target))
             - $signed(REL_BITS'(offset) + REL_BITS'(len));
  assign rel32    = 32'(rel);
  assign loop_err = (op == OP_LOOP) && ((rel < -128) || (rel > 127));

  // Build the byte group
  always_comb begin
    push_entry       = '0;
    push_entry.len   = len;
    push_entry.start = offset;
    unique case (op)
      OP_MOV_RR: begin
        push_entry.code[0] = OPC_MOV_STORE;
        push_entry.code[1] = {2'b11, s, f};
      end
      OP_MOV_LD: begin
        push_entry.code[0] = OPC_MOV_LOAD;
        push_entry.code[1] = {2'b00, f, s};
      end
      OP_MOV_ST: begin
        push_entry.code[0] = OPC_MOV_STORE;
        push_entry.code[1] = {2'b00, s, f};
      end
      OP_MOV_IMM: begin
        push_entry.code[0]   = OPC_MOV_IMM | {5'd0, f};
        push_entry.code[4:1] = imm_eff;
      end
      OP_ADD_RR, OP_SUB_RR, OP_CMP_RR: begin
        push_entry.code[0] = (op == OP_ADD_RR) ? OPC_ADD_RR :
                             (op == OP_SUB_RR) ? OPC_SUB_RR : OPC_CMP_RR;
        push_entry.code[1] = {2'b11, s, f};
      end
      OP_ADD_IMM, OP_SUB_IMM, OP_CMP_IMM: begin
        push_entry.code[0]   = OPC_GRP1_IMM;
        push_entry.code[1]   = ((op == OP_ADD_IMM) ? MODRM_ADD_IMM :
                                (op == OP_SUB_IMM) ? MODRM_SUB_IMM : MODRM_CMP_IMM)
                             | {5'd0, f};
        push_entry.code[5:2] = imm_eff;
      end
      OP_INT: begin
        push_entry.code[0] = OPC_INT;
        push_entry.code[1] = imm_eff[7:0];
      end
      OP_INC:  push_entry.code[0] = OPC_INC | {5'd0, f};
      OP_DEC:  push_entry.code[0] = OPC_DEC | {5'd0, f};
      OP_JMP, OP_CALL: begin
        push_entry.code[0]   = (op == OP_JMP) ? OPC_JMP : OPC_CALL;
        push_entry.code[4:1] = rel32;
      end
      OP_JE, OP_JNE: begin
        push_entry.code[0]   = OPC_TWO_BYTE;
        push_entry.code[1]   = (op == OP_JE) ? OPC_JE_2ND : OPC_JNE_2ND;
        push_entry.code[5:2] = rel32;
      end
      OP_LOOP: begin
        if (loop_err) begin
          // Single flagged result with a zero byte
          push_entry.len = 3'd1;
          push_entry.err = 1'b1;
        end else begin
          push_entry.code[0] = OPC_LOOP;
          push_entry.code[1] = rel32[7:0];
        end
      end
      OP_PUSH: push_entry.code[0] = OPC_PUSH | {5'd0, f};
      OP_POP:  push_entry.code[0] = OPC_POP | {5'd0, f};
      OP_RET:  push_entry.code[0] = OPC_RET;
      OP_NOP:  push_entry.code[0] = OPC_NOP;
      OP_DATA: push_entry.code[0] = imm_eff[7:0];
      default: push_entry.code = '0;
    endcase
  end

  // Queue an entry for every known instruction; drop unknown codes
  assign push    = accept && known;
  assign advance = loop_err ? 3'd0 : len;

  // Hold configuration and the running offset
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
      offset    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        load_base <= cfg_data;
      end
      if (push) begin
        offset <= OFFSET_BITS'(offset + OFFSET_BITS'(advance));
      end
    end
  end

endmodule

// ===== rtl/x86enc_queue.sv =====
// Short request queue between the encoder front and the byte emitter.
// Depends on x86enc_pkg.
module x86enc_queue import x86enc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  enc_entry_t push_entry,
  input  logic       pop,
  output q_stat_t    q_stat,
  output enc_entry_t head
);

  enc_entry_t           entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign q_stat.valid = (count != '0);
  assign q_stat.full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign head         = entries[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : QPTR_BITS'(rd_ptr + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/x86enc_back.sv =====
// Back end: walks the head entry into the output register one byte per cycle
// while the output is not stalled. Depends on x86enc_pkg.
module x86enc_back import x86enc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_stat_t     q_stat,
  input  enc_entry_t  head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  output logic [0:0]  m_tuser
);

  logic [2:0]             idx;
  logic                   take;
  logic                   last_byte;
  logic [OFFSET_BITS-1:0] addr;
  logic [7:0]             code_byte;
  logic [15:0]            byte_address;
  logic                   err;

  assign take      = q_stat.valid && (!m_tvalid || m_tready);
  assign last_byte = head.err || (idx == (head.len - 3'd1));
  assign pop       = take && last_byte;
  assign addr      = OFFSET_BITS'(head.start + OFFSET_BITS'(idx));

  assign m_tdata   = {byte_address, code_byte};
  assign m_tuser   = err;

  // Load the next byte when the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (take) begin
        m_tvalid <= 1'b1;
        idx      <= last_byte ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      code_byte    <= head.code[idx];
      byte_address <= 16'(addr);
      m_tlast      <= last_byte;
      err          <= head.err;
    end
  end

endmodule
